### src/spi_pkg.sv
// ---------------------------------------------------------------------------
// Segment plane intersect package
// Widths and codes shared by the intersect datapath and its port checker,
// and the pipeline stage types of the datapath.
// ---------------------------------------------------------------------------
package spi_pkg;

   // Fixed point formats.
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int NORM_WIDTH  = 18;
   localparam int NORM_FRAC   = 16;

   // Datapath widths, all derived from the formats above.
   localparam int DIR_W  = COORD_WIDTH + 1;
   localparam int PD_W   = DIR_W + NORM_WIDTH;
   localparam int PS_W   = COORD_WIDTH + NORM_WIDTH;
   localparam int DEN_W  = PD_W + 2;
   localparam int SDOT_W = PS_W + 2;
   localparam int NUM_W  = SDOT_W + 1 + FRAC_BITS;
   localparam int QUO_W  = COORD_WIDTH + 1;
   localparam int REM_W  = DEN_W;
   localparam int TN_W   = FRAC_BITS + 1;
   localparam int MUL_W  = DIR_W + TN_W + 1;
   localparam int STEP_W = MUL_W - FRAC_BITS;

   // Stream and register port widths.
   localparam int STATUS_W     = 2;
   localparam int IN_W         = ((6 * COORD_WIDTH + 7) / 8) * 8;
   localparam int OUT_FIELDS_W = STATUS_W + 4 * COORD_WIDTH;
   localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = (COORD_WIDTH > NORM_WIDTH) ? COORD_WIDTH : NORM_WIDTH;

   // Field positions in the result word.
   localparam int T_LSB     = STATUS_W;
   localparam int HIT_X_LSB = T_LSB + COORD_WIDTH;
   localparam int HIT_Y_LSB = HIT_X_LSB + COORD_WIDTH;
   localparam int HIT_Z_LSB = HIT_Y_LSB + COORD_WIDTH;

   localparam logic signed [COORD_WIDTH-1:0] T_ONE       = COORD_WIDTH'(1 << FRAC_BITS);
   localparam logic signed [COORD_WIDTH-1:0] T_MINUS_ONE = -T_ONE;
   localparam logic signed [COORD_WIDTH-1:0] T_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] T_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic signed [NORM_WIDTH-1:0]  NORMAL_Z_RESET = NORM_WIDTH'(1 << NORM_FRAC);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_HIT      = 2'd0,
      STATUS_PARALLEL = 2'd1,
      STATUS_OUTSIDE  = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NORMAL_X     = 2'd0,
      CSR_NORMAL_Y     = 2'd1,
      CSR_NORMAL_Z     = 2'd2,
      CSR_PLANE_OFFSET = 2'd3
   } csr_index_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [NORM_WIDTH-1:0]  norm_type;
   typedef logic signed [DIR_W-1:0]       dir_type;
   typedef logic signed [PD_W-1:0]        pd_type;
   typedef logic signed [PS_W-1:0]        ps_type;
   typedef logic signed [DEN_W-1:0]       den_type;
   typedef logic signed [SDOT_W-1:0]      sdot_type;
   typedef logic signed [NUM_W-1:0]       num_type;
   typedef logic [DEN_W-1:0]              den_mag_type;
   typedef logic [NUM_W-1:0]              num_mag_type;
   typedef logic [REM_W-1:0]              rem_type;
   typedef logic [QUO_W-1:0]              quo_type;
   typedef logic [TN_W-1:0]               tn_type;
   typedef logic signed [MUL_W-1:0]       prod_type;
   typedef logic signed [STEP_W-1:0]      step_type;

   // Segment geometry carried down the pipeline.
   typedef struct packed {
      coord_type [2:0] s;
      dir_type   [2:0] d;
   } geo_type;

   typedef struct packed {
      geo_type         geo;
      pd_type    [2:0] pd;
      ps_type    [2:0] ps;
   } dot_stage_type;

   typedef struct packed {
      geo_type  geo;
      den_type  den;
      sdot_type sdot;
   } sum_stage_type;

   typedef struct packed {
      geo_type geo;
      den_type den;
      num_type num;
   } frac_stage_type;

   typedef struct packed {
      geo_type     geo;
      logic        neg;
      logic        par;
      den_mag_type den_mag;
      num_mag_type num_mag;
   } mag_stage_type;

   typedef struct packed {
      geo_type     geo;
      logic        neg;
      logic        par;
      logic        ovf;
      rem_type     rem;
      den_mag_type den_mag;
      quo_type     num_lo;
      quo_type     quo;
   } div_stage_type;

   typedef struct packed {
      geo_type   geo;
      logic      par;
      coord_type t;
   } sat_stage_type;

   typedef struct packed {
      geo_type    geo;
      status_type status;
      coord_type  t;
      tn_type     tn;
   } cls_stage_type;

   typedef struct packed {
      coord_type [2:0] s;
      status_type      status;
      coord_type       t;
      prod_type  [2:0] p;
   } mul_stage_type;

   typedef struct packed {
      coord_type [2:0] s;
      status_type      status;
      coord_type       t;
      step_type  [2:0] step;
   } step_stage_type;

   typedef struct packed {
      status_type      status;
      coord_type       t;
      coord_type [2:0] hit;
   } res_stage_type;

endpackage

### src/segment_plane_intersect_top.sv
// ---------------------------------------------------------------------------
// Segment plane intersect
// Tests one segment per clock, unless stalled, against the configured plane
// and returns the status, the segment parameter t and the hit point.
// ---------------------------------------------------------------------------
// The block takes one segment word per clock while the skid register is free
// and returns one result word per segment, in order. A segment passes through
// QUO_W + 12 registers on its way to rsp_tdata. The quotient width sets the
// depth. Five stages form the direction, the dot products, the numerator and
// the magnitudes. They are followed by a restoring divider: one setup stage,
// then 33 stages that each make one quotient bit. Five stages of saturation,
// classification and hit point arithmetic come next, and the output register
// is last. The output register is backed by a skid register, which keeps the
// input open while a result waits. req_tready drops only once both hold a
// word. The pipeline reads the plane registers live, so write them only while
// no segment is in flight.
module segment_plane_intersect_top (
   input  logic                          clock,
   input  logic                          reset,
   // start_x, start_y, start_z, end_x, end_y, end_z from the lowest bit up
   input  logic [spi_pkg::IN_W-1:0]      req_tdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // status, t_param, hit_x, hit_y, hit_z from the lowest bit up, zero filled
   output logic [spi_pkg::OUT_W-1:0]     rsp_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_wr_en,
   input  logic [spi_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [spi_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import spi_pkg::*;

   // Stage positions in the valid shift register.
   localparam int DIV0_IDX = 5;
   localparam int NSTAGE   = DIV0_IDX + QUO_W + 6;

   // Plane registers.
   norm_type  normal_x_ff, normal_x_in;
   norm_type  normal_y_ff, normal_y_in;
   norm_type  normal_z_ff, normal_z_in;
   coord_type plane_offset_ff, plane_offset_in;
   norm_type  normal_ff [3];

   logic [NSTAGE-1:0] valid_ff, valid_in;
   logic              adv;

   geo_type        s1_ff, s1_in;
   dot_stage_type  s2_ff, s2_in;
   sum_stage_type  s3_ff, s3_in;
   frac_stage_type s4_ff, s4_in;
   mag_stage_type  s5_ff, s5_in;
   div_stage_type  div_ff [QUO_W+1];
   div_stage_type  div_in [QUO_W+1];
   sat_stage_type  sat_ff, sat_in;
   cls_stage_type  cls_ff, cls_in;
   mul_stage_type  mul_ff, mul_in;
   step_stage_type stp_ff, stp_in;
   res_stage_type  res_ff, res_in;

   logic [OUT_W-1:0] last_word;
   logic             take_last;
   logic [OUT_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] skid_data_ff, skid_data_in;
   logic             skid_valid_ff, skid_valid_in;

   // The pipeline moves whenever the skid register is free.
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;

   assign normal_ff[0] = normal_x_ff;
   assign normal_ff[1] = normal_y_ff;
   assign normal_ff[2] = normal_z_ff;

   // ---------------- configuration ----------------
   always_comb begin
      normal_x_in     = normal_x_ff;
      normal_y_in     = normal_y_ff;
      normal_z_in     = normal_z_ff;
      plane_offset_in = plane_offset_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_NORMAL_X:     normal_x_in     = csr_wdata[NORM_WIDTH-1:0];
            CSR_NORMAL_Y:     normal_y_in     = csr_wdata[NORM_WIDTH-1:0];
            CSR_NORMAL_Z:     normal_z_in     = csr_wdata[NORM_WIDTH-1:0];
            CSR_PLANE_OFFSET: plane_offset_in = csr_wdata[COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_x_ff     <= '0;
         normal_y_ff     <= '0;
         normal_z_ff     <= NORMAL_Z_RESET;
         plane_offset_ff <= '0;
      end else begin
         normal_x_ff     <= normal_x_in;
         normal_y_ff     <= normal_y_in;
         normal_z_ff     <= normal_z_in;
         plane_offset_ff <= plane_offset_in;
      end
   end

   // ---------------- front stages: direction and dot products ----------------
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_in.s[i] = req_tdata[i*COORD_WIDTH +: COORD_WIDTH];
         s1_in.d[i] = DIR_W'($signed(req_tdata[(i+3)*COORD_WIDTH +: COORD_WIDTH]))
                    - DIR_W'($signed(req_tdata[i*COORD_WIDTH +: COORD_WIDTH]));
      end

      s2_in.geo = s1_ff;
      for (int i = 0; i < 3; i++) begin
         s2_in.pd[i] = PD_W'($signed(s1_ff.d[i])) * PD_W'($signed(normal_ff[i]));
         s2_in.ps[i] = PS_W'($signed(s1_ff.s[i])) * PS_W'($signed(normal_ff[i]));
      end

      s3_in.geo  = s2_ff.geo;
      s3_in.den  = DEN_W'($signed(s2_ff.pd[0])) + DEN_W'($signed(s2_ff.pd[1]))
                 + DEN_W'($signed(s2_ff.pd[2]));
      s3_in.sdot = SDOT_W'($signed(s2_ff.ps[0])) + SDOT_W'($signed(s2_ff.ps[1]))
                 + SDOT_W'($signed(s2_ff.ps[2]));

      // Numerator (offset - start.n) scaled up by the t fraction bits.
      s4_in.geo = s3_ff.geo;
      s4_in.den = s3_ff.den;
      s4_in.num = (NUM_W'($signed(plane_offset_ff)) <<< (NORM_FRAC + FRAC_BITS))
                - (NUM_W'($signed(s3_ff.sdot)) <<< FRAC_BITS);

      s5_in.geo     = s4_ff.geo;
      s5_in.neg     = s4_ff.num[NUM_W-1] ^ s4_ff.den[DEN_W-1];
      s5_in.par     = (s4_ff.den == '0);
      s5_in.den_mag = s4_ff.den[DEN_W-1] ? den_mag_type'(-s4_ff.den) : den_mag_type'(s4_ff.den);
      s5_in.num_mag = s4_ff.num[NUM_W-1] ? num_mag_type'(-s4_ff.num) : num_mag_type'(s4_ff.num);
   end

   // ---------------- restoring divider, one quotient bit per stage ----------------
   genvar k;
   for (k = 0; k <= QUO_W; k++) begin : g_div
      if (k == 0) begin : g_init
         div_stage_type init_v;
         always_comb begin
            init_v.geo     = s5_ff.geo;
            init_v.neg     = s5_ff.neg;
            init_v.par     = s5_ff.par;
            // A quotient of 2**QUO_W or more saturates whatever its low bits are.
            init_v.ovf     = ({{DEN_W{1'b0}}, s5_ff.num_mag} >> QUO_W)
                          >= {{NUM_W{1'b0}}, s5_ff.den_mag};
            init_v.rem     = rem_type'(s5_ff.num_mag >> QUO_W);
            init_v.den_mag = s5_ff.den_mag;
            init_v.num_lo  = s5_ff.num_mag[QUO_W-1:0];
            init_v.quo     = '0;
         end
         assign div_in[k] = init_v;
      end else begin : g_step
         div_stage_type    step_v;
         logic [REM_W:0]   sh;
         logic [REM_W:0]   diff;
         logic             ge;
         always_comb begin
            sh   = {div_ff[k-1].rem, div_ff[k-1].num_lo[QUO_W-1]};
            diff = sh - {1'b0, div_ff[k-1].den_mag};
            ge   = (sh >= {1'b0, div_ff[k-1].den_mag});
            step_v        = div_ff[k-1];
            step_v.rem    = ge ? diff[REM_W-1:0] : sh[REM_W-1:0];
            step_v.num_lo = {div_ff[k-1].num_lo[QUO_W-2:0], 1'b0};
            step_v.quo    = {div_ff[k-1].quo[QUO_W-2:0], ge};
         end
         assign div_in[k] = step_v;
      end
   end

   // ---------------- back stages: saturation, class, hit point ----------------
   always_comb begin
      logic pos_big;
      logic neg_big;

      pos_big = div_ff[QUO_W].ovf || (div_ff[QUO_W].quo > {1'b0, T_MAX});
      neg_big = div_ff[QUO_W].ovf || (div_ff[QUO_W].quo > ({1'b0, T_MAX} + QUO_W'(1)));
      sat_in.geo = div_ff[QUO_W].geo;
      sat_in.par = div_ff[QUO_W].par;
      if (div_ff[QUO_W].par) begin
         sat_in.t = T_MINUS_ONE;
      end else if (!div_ff[QUO_W].neg) begin
         sat_in.t = pos_big ? T_MAX : coord_type'(div_ff[QUO_W].quo[COORD_WIDTH-1:0]);
      end else begin
         sat_in.t = neg_big ? T_MIN : coord_type'(-div_ff[QUO_W].quo[COORD_WIDTH-1:0]);
      end

      cls_in.geo = sat_ff.geo;
      cls_in.t   = sat_ff.t;
      cls_in.tn  = sat_ff.t[TN_W-1:0];
      if (sat_ff.par) begin
         cls_in.status = STATUS_PARALLEL;
      end else if ((sat_ff.t < 0) || (sat_ff.t > T_ONE)) begin
         cls_in.status = STATUS_OUTSIDE;
      end else begin
         cls_in.status = STATUS_HIT;
      end

      mul_in.s      = cls_ff.geo.s;
      mul_in.status = cls_ff.status;
      mul_in.t      = cls_ff.t;
      for (int i = 0; i < 3; i++) begin
         mul_in.p[i] = MUL_W'($signed(cls_ff.geo.d[i])) * MUL_W'($signed({1'b0, cls_ff.tn}));
      end

      // Truncate toward zero: negative products get a bias before the shift.
      stp_in.s      = mul_ff.s;
      stp_in.status = mul_ff.status;
      stp_in.t      = mul_ff.t;
      for (int i = 0; i < 3; i++) begin
         logic signed [MUL_W-1:0] biased;
         biased = mul_ff.p[i]
                + (mul_ff.p[i][MUL_W-1] ? MUL_W'((64'd1 << FRAC_BITS) - 64'd1) : MUL_W'(0));
         stp_in.step[i] = biased[MUL_W-1:FRAC_BITS];
      end

      res_in.status = stp_ff.status;
      res_in.t      = stp_ff.t;
      for (int i = 0; i < 3; i++) begin
         logic signed [STEP_W-1:0] pt;
         pt = STEP_W'($signed(stp_ff.s[i])) + $signed(stp_ff.step[i]);
         res_in.hit[i] = (stp_ff.status == STATUS_HIT) ? pt[COORD_WIDTH-1:0] : '0;
      end
   end

   assign valid_in = adv ? {valid_ff[NSTAGE-2:0], req_tvalid} : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         for (int i = 0; i <= QUO_W; i++) begin
            div_ff[i] <= div_in[i];
         end
         sat_ff <= sat_in;
         cls_ff <= cls_in;
         mul_ff <= mul_in;
         stp_ff <= stp_in;
         res_ff <= res_in;
      end
   end

   // ---------------- output register and skid ----------------
   assign last_word = OUT_W'({res_ff.hit[2], res_ff.hit[1], res_ff.hit[0],
                              res_ff.t, res_ff.status});
   assign take_last = adv && valid_ff[NSTAGE-1];

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_valid_ff && !rsp_tready) begin
         if (take_last) begin
            skid_valid_in = 1'b1;
            skid_data_in  = last_word;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else begin
         rsp_valid_in = take_last;
         rsp_data_in  = last_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### src/spi_checker.sv
// ---------------------------------------------------------------------------
// Segment plane intersect port checker
// Watches the result stream of the intersect block for field consistency,
// for a word that drops or changes while it waits and for a word after reset.
// ---------------------------------------------------------------------------
module spi_checker (
   input logic                     clock,
   input logic                     reset,
   input logic [spi_pkg::OUT_W-1:0] rsp_tdata,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready
);
   import spi_pkg::*;

   logic [STATUS_W-1:0]           status_val;
   logic signed [COORD_WIDTH-1:0] t_val;
   logic                          hits_zero;

   assign status_val = rsp_tdata[STATUS_W-1:0];
   assign t_val      = rsp_tdata[T_LSB +: COORD_WIDTH];
   assign hits_zero  = (rsp_tdata[HIT_X_LSB +: COORD_WIDTH] == '0)
                    && (rsp_tdata[HIT_Y_LSB +: COORD_WIDTH] == '0)
                    && (rsp_tdata[HIT_Z_LSB +: COORD_WIDTH] == '0);

   // A parallel segment always reports t of minus one and no point.
   a_parallel : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status_val == STATUS_PARALLEL) |-> (t_val == T_MINUS_ONE) && hits_zero)
      else $error("parallel result with wrong t or nonzero point");

   // A miss reports a t outside the unit interval and no point.
   a_outside : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status_val == STATUS_OUTSIDE)
         |-> hits_zero && ((t_val < 0) || (t_val > T_ONE)))
      else $error("outside result with t in range or nonzero point");

   // A hit needs t within the unit interval.
   a_hit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status_val == STATUS_HIT) |-> (t_val >= 0) && (t_val <= T_ONE))
      else $error("hit result with t out of range");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed while stalled");

   a_reset : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word shown right after reset");

endmodule

bind segment_plane_intersect_top spi_checker u_spi_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
